>>> src/msup_pkg.sv
package msup_pkg;

  // Mode codes as carried on the mode output and held in the mode register
  typedef enum logic [2:0] {
    MODE_RESET      = 3'd0,
    MODE_LOSTCTRL   = 3'd1,
    MODE_PREBALANCE = 3'd2,
    MODE_BALANCE    = 3'd3,
    MODE_WEIGHTLESS = 3'd4,
    MODE_FALLEN     = 3'd5,
    MODE_RESCUE     = 3'd6,
    MODE_SPARE      = 3'd7
  } mode_t;

  // Register map, word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_BALANCE_PITCH  = 3'd0,
    REG_FALL_PITCH     = 3'd1,
    REG_FALL_PITCH_LEAP = 3'd2,
    REG_FALL_ROLL      = 3'd3,
    REG_FALL_ROLL_FAST = 3'd4,
    REG_OVERTURN_PITCH = 3'd5,
    REG_OVERTURN_ROLL  = 3'd6,
    REG_LEG_FORCE_HEIGHT = 3'd7
  } reg_idx_t;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int ANGLE_LIM_W = 15;
  localparam int LEN_W = 10;

  localparam logic signed [15:0] BALANCE_TICKS = 16'sd100;
  localparam logic signed [15:0] FALL_TICKS    = 16'sd50;
  localparam logic signed [15:0] PROTECT_TICKS = 16'sd500;
  localparam logic signed [7:0]  STILL_TICKS   = 8'sd50;

  localparam logic [LEN_W-1:0] FOLD_LEN  = 10'd150;
  localparam logic [15:0]      LOW_SPEED = 16'd500;

  typedef struct packed {
    logic [ANGLE_LIM_W-1:0] balance_pitch_limit;
    logic [ANGLE_LIM_W-1:0] fall_pitch_limit;
    logic [ANGLE_LIM_W-1:0] fall_pitch_limit_leap;
    logic [ANGLE_LIM_W-1:0] fall_roll_limit;
    logic [ANGLE_LIM_W-1:0] fall_roll_fast_limit;
    logic [ANGLE_LIM_W-1:0] overturn_pitch_limit;
    logic [ANGLE_LIM_W-1:0] overturn_roll_limit;
    logic [LEN_W-1:0]       leg_force_height;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] body_roll;
    logic signed [15:0] wheel_speed;
    logic [LEN_W-1:0]   commanded_height;
    logic               remote_on;
    logic               enable_request;
    logic               rescue_request;
    logic               light_weightless;
    logic               leap_mode;
  } tick_t;

  typedef struct packed {
    mode_t            mode;
    logic             chassis_on;
    logic             leg_force_on;
    logic             wheel_on;
    logic [LEN_W-1:0] leg_length_target;
    logic             balanced;
    logic             fallen;
    logic             overturned;
    logic             recalibrate_pulse;
  } result_t;

endpackage

>>> src/msup_regs.sv
module msup_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msup_pkg::ADDR_W-1:0]  paddr,
  input  logic [msup_pkg::DATA_W-1:0]  pwdata,
  output logic [msup_pkg::DATA_W-1:0]  prdata,
  output msup_pkg::cfg_t               cfg
);
  import msup_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.balance_pitch_limit   <= 15'd1500;
      cfg.fall_pitch_limit      <= 15'd1600;
      cfg.fall_pitch_limit_leap <= 15'd2000;
      cfg.fall_roll_limit       <= 15'd1800;
      cfg.fall_roll_fast_limit  <= 15'd2200;
      cfg.overturn_pitch_limit  <= 15'd5000;
      cfg.overturn_roll_limit   <= 15'd4500;
      cfg.leg_force_height      <= 10'd160;
    end else if (wr) begin
      unique case (idx)
        REG_BALANCE_PITCH:    cfg.balance_pitch_limit   <= pwdata[ANGLE_LIM_W-1:0];
        REG_FALL_PITCH:       cfg.fall_pitch_limit      <= pwdata[ANGLE_LIM_W-1:0];
        REG_FALL_PITCH_LEAP:  cfg.fall_pitch_limit_leap <= pwdata[ANGLE_LIM_W-1:0];
        REG_FALL_ROLL:        cfg.fall_roll_limit       <= pwdata[ANGLE_LIM_W-1:0];
        REG_FALL_ROLL_FAST:   cfg.fall_roll_fast_limit  <= pwdata[ANGLE_LIM_W-1:0];
        REG_OVERTURN_PITCH:   cfg.overturn_pitch_limit  <= pwdata[ANGLE_LIM_W-1:0];
        REG_OVERTURN_ROLL:    cfg.overturn_roll_limit   <= pwdata[ANGLE_LIM_W-1:0];
        REG_LEG_FORCE_HEIGHT: cfg.leg_force_height      <= pwdata[LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BALANCE_PITCH:    prdata = DATA_W'(cfg.balance_pitch_limit);
      REG_FALL_PITCH:       prdata = DATA_W'(cfg.fall_pitch_limit);
      REG_FALL_PITCH_LEAP:  prdata = DATA_W'(cfg.fall_pitch_limit_leap);
      REG_FALL_ROLL:        prdata = DATA_W'(cfg.fall_roll_limit);
      REG_FALL_ROLL_FAST:   prdata = DATA_W'(cfg.fall_roll_fast_limit);
      REG_OVERTURN_PITCH:   prdata = DATA_W'(cfg.overturn_pitch_limit);
      REG_OVERTURN_ROLL:    prdata = DATA_W'(cfg.overturn_roll_limit);
      REG_LEG_FORCE_HEIGHT: prdata = DATA_W'(cfg.leg_force_height);
    endcase
  end

endmodule

>>> src/msup_core.sv
module msup_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  msup_pkg::tick_t   tick,
  input  msup_pkg::cfg_t    cfg,
  output msup_pkg::result_t res
);
  import msup_pkg::*;

  // supervisor state
  mode_t              mode_reg;
  logic               reset_done;
  logic               balanced_reg, fallen_reg;
  logic               chassis_reg, leg_force_reg, wheel_reg;
  logic [LEN_W-1:0]   length_reg;
  logic signed [15:0] balance_count, fall_count, protect_count;
  logic signed [7:0]  still_count;

  mode_t              mode_reg_next;
  logic               reset_done_next;
  logic               balanced_reg_next, fallen_reg_next;
  logic               chassis_reg_next, leg_force_reg_next, wheel_reg_next;
  logic [LEN_W-1:0]   length_reg_next;
  logic signed [15:0] balance_count_next, fall_count_next, protect_count_next;
  logic signed [7:0]  still_count_next;

  logic [15:0] ap, ar, sp;
  logic        wl, over, recal;
  mode_t       sel, shown;
  logic [ANGLE_LIM_W-1:0] pitch_lim;

  // magnitudes; 16 bits unsigned hold 32768
  assign ap = tick.pitch_angle[15] ? 16'(-tick.pitch_angle) : 16'(tick.pitch_angle);
  assign ar = tick.body_roll[15]   ? 16'(-tick.body_roll)   : 16'(tick.body_roll);
  assign sp = tick.wheel_speed[15] ? 16'(-tick.wheel_speed) : 16'(tick.wheel_speed);

  assign wl        = tick.light_weightless && leg_force_reg;
  assign over      = (ap > {1'b0, cfg.overturn_pitch_limit}) ||
                     (ar > {1'b0, cfg.overturn_roll_limit});
  assign pitch_lim = tick.leap_mode ? cfg.fall_pitch_limit_leap : cfg.fall_pitch_limit;

  always_comb begin
    priority if (!reset_done)              sel = MODE_RESET;
    else if (over || fallen_reg)           sel = MODE_FALLEN;
    else if (!tick.remote_on)              sel = MODE_LOSTCTRL;
    else if (tick.rescue_request)          sel = MODE_RESCUE;
    else if (mode_reg == MODE_LOSTCTRL || !tick.enable_request) sel = MODE_PREBALANCE;
    else                                   sel = mode_reg;
  end

  always_comb begin
    mode_reg_next      = sel;
    reset_done_next    = reset_done;
    balanced_reg_next  = balanced_reg;
    fallen_reg_next    = fallen_reg;
    chassis_reg_next   = chassis_reg;
    leg_force_reg_next = leg_force_reg;
    wheel_reg_next     = wheel_reg;
    length_reg_next    = length_reg;
    balance_count_next = balance_count;
    fall_count_next    = fall_count;
    protect_count_next = protect_count;
    still_count_next   = still_count;
    recal              = 1'b0;
    shown              = sel;

    unique case (sel)
      MODE_RESET: begin
        balanced_reg_next = 1'b0;
        fallen_reg_next   = 1'b0;
        recal             = 1'b1;
        reset_done_next   = 1'b1;
        mode_reg_next     = MODE_LOSTCTRL;
      end
      MODE_PREBALANCE: begin
        balanced_reg_next  = 1'b0;
        fallen_reg_next    = 1'b0;
        chassis_reg_next   = 1'b1;
        leg_force_reg_next = 1'b0;
        wheel_reg_next     = 1'b0;
        length_reg_next    = FOLD_LEN;
        if (tick.enable_request) mode_reg_next = MODE_BALANCE;
      end
      MODE_BALANCE: begin
        chassis_reg_next = 1'b1;
        // balance debounce
        if (!balanced_reg) begin
          balance_count_next = (ap < {1'b0, cfg.balance_pitch_limit}) ?
                               balance_count - 16'sd1 : BALANCE_TICKS;
          if (balance_count_next < 0) begin
            balanced_reg_next  = 1'b1;
            balance_count_next = BALANCE_TICKS;
          end
        end
        // protection window, clamped to [1, PROTECT_TICKS]
        protect_count_next = protect_count - 16'sd1;
        if (protect_count_next < 16'sd1) protect_count_next = 16'sd1;
        if (protect_count_next > PROTECT_TICKS) protect_count_next = PROTECT_TICKS;
        // fall debounce; uses leg force from before this tick
        if (!fallen_reg && leg_force_reg) begin
          if (protect_count_next == 16'sd1) begin
            priority if (ar > {1'b0, cfg.fall_roll_fast_limit})
              fall_count_next = fall_count - 16'sd5;
            else if (ap > {1'b0, pitch_lim} || ar > {1'b0, cfg.fall_roll_limit})
              fall_count_next = fall_count - 16'sd1;
            else
              fall_count_next = FALL_TICKS;
          end else if (ap > {1'b0, pitch_lim}) begin
            fall_count_next = fall_count - 16'sd1;
          end
          if (fall_count_next < 0) begin
            fallen_reg_next    = 1'b1;
            fall_count_next    = FALL_TICKS;
            protect_count_next = PROTECT_TICKS;
          end
        end
        length_reg_next    = tick.commanded_height;
        leg_force_reg_next = tick.commanded_height > cfg.leg_force_height;
        wheel_reg_next     = 1'b1;
        if (wl) mode_reg_next = MODE_WEIGHTLESS;
      end
      MODE_WEIGHTLESS: begin
        chassis_reg_next   = 1'b1;
        leg_force_reg_next = 1'b1;
        if (!wl) mode_reg_next = MODE_BALANCE;
      end
      MODE_FALLEN: begin
        balanced_reg_next  = 1'b0;
        leg_force_reg_next = 1'b0;
        wheel_reg_next     = 1'b0;
        length_reg_next    = FOLD_LEN;
        chassis_reg_next   = 1'b1;
        if (sp < LOW_SPEED) begin
          still_count_next = still_count - 8'sd1;
          if (still_count_next < 0) begin
            still_count_next = STILL_TICKS;
            mode_reg_next    = MODE_PREBALANCE;
            fallen_reg_next  = 1'b0;
          end
        end else begin
          still_count_next = STILL_TICKS;
        end
      end
      MODE_RESCUE: begin
        balanced_reg_next  = 1'b0;
        fallen_reg_next    = 1'b0;
        chassis_reg_next   = 1'b1;
        wheel_reg_next     = 1'b1;
        leg_force_reg_next = 1'b0;
        length_reg_next    = FOLD_LEN;
        if (!tick.rescue_request) begin
          mode_reg_next      = MODE_PREBALANCE;
          protect_count_next = PROTECT_TICKS;
        end
      end
      MODE_LOSTCTRL, MODE_SPARE: begin
        // spare code is unreachable; treated as lost control
        shown              = MODE_LOSTCTRL;
        mode_reg_next      = (sel == MODE_SPARE) ? MODE_LOSTCTRL : sel;
        balanced_reg_next  = 1'b0;
        fallen_reg_next    = 1'b0;
        chassis_reg_next   = 1'b0;
        leg_force_reg_next = 1'b0;
        wheel_reg_next     = 1'b0;
        length_reg_next    = FOLD_LEN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_RESET;
      reset_done    <= 1'b0;
      balanced_reg  <= 1'b0;
      fallen_reg    <= 1'b0;
      chassis_reg   <= 1'b0;
      leg_force_reg <= 1'b0;
      wheel_reg     <= 1'b0;
      length_reg    <= FOLD_LEN;
      balance_count <= BALANCE_TICKS;
      fall_count    <= FALL_TICKS;
      protect_count <= PROTECT_TICKS;
      still_count   <= STILL_TICKS;
    end else if (step) begin
      mode_reg      <= mode_reg_next;
      reset_done    <= reset_done_next;
      balanced_reg  <= balanced_reg_next;
      fallen_reg    <= fallen_reg_next;
      chassis_reg   <= chassis_reg_next;
      leg_force_reg <= leg_force_reg_next;
      wheel_reg     <= wheel_reg_next;
      length_reg    <= length_reg_next;
      balance_count <= balance_count_next;
      fall_count    <= fall_count_next;
      protect_count <= protect_count_next;
      still_count   <= still_count_next;
    end
  end

  always_comb begin
    res.mode              = shown;
    res.chassis_on        = chassis_reg_next;
    res.leg_force_on      = leg_force_reg_next;
    res.wheel_on          = wheel_reg_next;
    res.leg_length_target = length_reg_next;
    res.balanced          = balanced_reg_next;
    res.fallen            = fallen_reg_next;
    res.overturned        = over;
    res.recalibrate_pulse = recal;
  end

endmodule

>>> src/balance_robot_mode_supervisor_top.sv
// Mode supervisor for a two-wheeled legged balance robot. Each input word is one
// control tick (pitch, roll, wheel speed, commanded leg height, command flags);
// each tick yields exactly one result word carrying the mode whose handler ran,
// the chassis / leg-force / wheel enables, the leg length target, the balanced
// and fallen flags, the overturn flag and a recalibration pulse. A word is
// registered on entry, evaluated by a single pass of compare-and-select logic
// against the supervisor state, and lands in an output register once that
// register is free or draining. Sustained rate is one word per clock while
// the output is not stalled; the state feedback runs through that one
// evaluation stage. The output register lets the next word be taken while
// a result waits.
// Thresholds sit in an APB register file (word index = paddr[4:2]); write it
// only while no tick is in flight.
module balance_robot_mode_supervisor_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msup_pkg::ADDR_W-1:0]       paddr,
  input  logic [msup_pkg::DATA_W-1:0]       pwdata,
  output logic [msup_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  // tick input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [15:0]                pitch_angle,
  input  logic signed [15:0]                body_roll,
  input  logic signed [15:0]                wheel_speed,
  input  logic [msup_pkg::LEN_W-1:0]        commanded_height,
  input  logic                              remote_on,
  input  logic                              enable_request,
  input  logic                              rescue_request,
  input  logic                              light_weightless,
  input  logic                              leap_mode,
  // result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        mode,
  output logic                              chassis_on,
  output logic                              leg_force_on,
  output logic                              wheel_on,
  output logic [msup_pkg::LEN_W-1:0]        leg_length_target,
  output logic                              balanced,
  output logic                              fallen,
  output logic                              overturned,
  output logic                              recalibrate_pulse
);
  import msup_pkg::*;

  cfg_t    cfg;
  tick_t   tick_in, tick_q;
  result_t res, res_q;
  logic    in_full;
  logic    step;

  assign pready = 1'b1;

  msup_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .cfg    (cfg)
  );

  assign tick_in.pitch_angle      = pitch_angle;
  assign tick_in.body_roll        = body_roll;
  assign tick_in.wheel_speed      = wheel_speed;
  assign tick_in.commanded_height = commanded_height;
  assign tick_in.remote_on        = remote_on;
  assign tick_in.enable_request   = enable_request;
  assign tick_in.rescue_request   = rescue_request;
  assign tick_in.light_weightless = light_weightless;
  assign tick_in.leap_mode        = leap_mode;

  // evaluate the held word when the output register is free or draining
  assign step     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (step) begin
        in_full <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) tick_q <= tick_in;
    if (step)                 res_q  <= res;
  end

  msup_core u_core (
    .clk (clk),
    .rst (rst),
    .step(step),
    .tick(tick_q),
    .cfg (cfg),
    .res (res)
  );

  assign mode              = res_q.mode;
  assign chassis_on        = res_q.chassis_on;
  assign leg_force_on      = res_q.leg_force_on;
  assign wheel_on          = res_q.wheel_on;
  assign leg_length_target = res_q.leg_length_target;
  assign balanced          = res_q.balanced;
  assign fallen            = res_q.fallen;
  assign overturned        = res_q.overturned;
  assign recalibrate_pulse = res_q.recalibrate_pulse;

endmodule

>>> src/msup_checker.sv
module msup_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 mode,
  input logic                       chassis_on,
  input logic                       leg_force_on,
  input logic                       wheel_on,
  input logic [msup_pkg::LEN_W-1:0] leg_length_target,
  input logic                       balanced,
  input logic                       fallen,
  input logic                       recalibrate_pulse
);
  import msup_pkg::*;

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(mode) &&
    $stable(leg_length_target))
    else $error("result word changed while stalled");

  // recalibration only on the reset tick
  a_recal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (recalibrate_pulse == (mode == MODE_RESET)))
    else $error("recalibrate pulse not tied to reset mode");

  // fallen: drives off, legs folded, chassis held on
  a_fallen_safe: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_FALLEN |->
    chassis_on && !wheel_on && !leg_force_on && !balanced &&
    leg_length_target == FOLD_LEN)
    else $error("fallen mode outputs not safe");

  // lost control: everything off, flags cleared
  a_lost_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode == MODE_LOSTCTRL |->
    !chassis_on && !wheel_on && !leg_force_on && !balanced && !fallen)
    else $error("lost control mode left outputs on");

endmodule

bind balance_robot_mode_supervisor_top msup_checker u_msup_checker (.*);
